FILE: design/cec_pkg.sv
// Shared constants, types and helpers for the cross erosion cell counter.
package cec_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int TOTAL_W = 21;

    localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

    // One column slot of the two line buffers.
    typedef struct packed {
        logic prev;   // row above
        logic older;  // row two above
    } line_bits_t;

    // Register value to (size - 1), with zero read as one and the top clamped.
    function automatic logic [COL_W-1:0] cols_m1_of(logic [CFG_W-1:0] raw);
        logic [31:0] v;
        v = 32'(raw);
        if (v == 32'd0) v = 32'd1;
        if (v > 32'(MAX_COLS)) v = 32'(MAX_COLS);
        return COL_W'(v - 32'd1);
    endfunction

    function automatic logic [ROW_W-1:0] rows_m1_of(logic [CFG_W-1:0] raw);
        logic [31:0] v;
        v = 32'(raw);
        if (v == 32'd0) v = 32'd1;
        if (v > 32'(MAX_ROWS)) v = 32'(MAX_ROWS);
        return ROW_W'(v - 32'd1);
    endfunction

endpackage

FILE: design/cross_erosion_cell_counter.sv
// Top level: raster-order cross erosion and count over a chain of line-buffer cells.
// Throughput: one cell per cycle; s_ready drops only when a grid's final cell arrives
//   while the previous total is still waiting on m_ready.
// The total shows on m_valid in the cycle after the final cell's transaction.
// Reset (aresetn low, synchronous): grid 1x1, positions and total cleared, no result
//   pending; the line-buffer cells are not reset and are read only once rewritten.
module cross_erosion_cell_counter (
    input  logic                           aclk,
    input  logic                           aresetn,
    // cell stream
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cell_empty,
    // total stream
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cec_pkg::TOTAL_W-1:0]    m_empty_core_total,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cec_pkg::CFG_W-1:0]      cfg_data
);

    // ---------------------------------------------------------------
    // Control and payload registers
    // ---------------------------------------------------------------
    logic [cec_pkg::ROW_W-1:0]   rows_m1_reg, rows_m1_next;
    logic [cec_pkg::COL_W-1:0]   cols_m1_reg, cols_m1_next;
    logic [cec_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [cec_pkg::COL_W-1:0]   col_reg, col_next;
    logic [cec_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        m_valid_reg, m_valid_next;
    logic [cec_pkg::TOTAL_W-1:0] result_reg, result_next;

    // Short history of the stream within the current row:
    // hist_above = (i-1, j-1), hist_cur1 = (i, j-1), hist_cur2 = (i, j-2).
    logic hist_above_reg, hist_above_next;
    logic hist_cur1_reg, hist_cur1_next;
    logic hist_cur2_reg, hist_cur2_next;

    logic s_accept;
    logic cfg_accept;

    // ---------------------------------------------------------------
    // Line-buffer chain. The head cell sits at column cols-1 so that a bit
    // written now reaches cell 0 exactly one row later.
    // ---------------------------------------------------------------
    cec_pkg::line_bits_t cell_bits [cec_pkg::MAX_COLS];
    cec_pkg::line_bits_t load_bits;

    logic above;

    assign load_bits.prev  = s_cell_empty;
    assign load_bits.older = above;

    for (genvar k = 0; k < cec_pkg::MAX_COLS; k++) begin : g_cell
        cec_pkg::line_bits_t next_bits;
        logic                is_head;

        if (k < cec_pkg::MAX_COLS - 1) begin : g_link
            assign next_bits = cell_bits[k + 1];
        end else begin : g_tail
            assign next_bits = '0;
        end

        assign is_head = (cols_m1_reg == cec_pkg::COL_W'(k));

        cec_cell u_cell (
            .aclk      (aclk),
            .shift_en  (s_accept),
            .is_head   (is_head),
            .load_bits (load_bits),
            .next_bits (next_bits),
            .bits      (cell_bits[k])
        );
    end

    // ---------------------------------------------------------------
    // Stencil decisions for the current transaction
    // ---------------------------------------------------------------
    logic cur;
    logic row_nz, row_ge2, col_nz, col_ge2;
    logic last_row, last_col, grid_done;
    logic hit_above, hit_left, hit_final;
    logic [1:0] hits;
    logic [cec_pkg::TOTAL_W:0] sum;

    always_comb begin
        cur      = s_cell_empty;
        above    = cell_bits[0].prev;
        row_nz   = (row_reg != '0);
        row_ge2  = row_nz && (row_reg != cec_pkg::ROW_W'(1));
        col_nz   = (col_reg != '0);
        col_ge2  = col_nz && (col_reg != cec_pkg::COL_W'(1));
        last_row = (row_reg == rows_m1_reg);
        last_col = (col_reg == cols_m1_reg);
        grid_done = last_row && last_col;

        // cell above, now that its lower neighbor is here
        hit_above = row_nz && above && cur
                  && (row_ge2 ? cell_bits[0].older : 1'b1)
                  && (col_nz ? hist_above_reg : 1'b1)
                  && (!last_col ? cell_bits[1].prev : 1'b1);

        // last row: cell to the left, now that its right neighbor is here
        hit_left = last_row && col_nz && hist_cur1_reg && cur
                 && (col_ge2 ? hist_cur2_reg : 1'b1)
                 && (row_nz ? hist_above_reg : 1'b1);

        // final cell of the grid
        hit_final = grid_done && cur
                  && (col_nz ? hist_cur1_reg : 1'b1)
                  && (row_nz ? above : 1'b1);

        hits = 2'(hit_above) + 2'(hit_left) + 2'(hit_final);
        sum  = {1'b0, total_reg} + (cec_pkg::TOTAL_W + 1)'(hits);
    end

    // stall only when a finished grid would overwrite an untaken total
    assign s_ready    = !(m_valid_reg && !m_ready && grid_done);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb begin
        rows_m1_next    = rows_m1_reg;
        cols_m1_next    = cols_m1_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        total_next      = total_reg;
        result_next     = result_reg;
        hist_above_next = hist_above_reg;
        hist_cur1_next  = hist_cur1_reg;
        hist_cur2_next  = hist_cur2_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (s_accept) begin
            hist_above_next = above;
            hist_cur1_next  = cur;
            hist_cur2_next  = hist_cur1_reg;
            if (sum > {1'b0, cec_pkg::TOTAL_LIMIT}) begin
                total_next = cec_pkg::TOTAL_LIMIT;
            end else begin
                total_next = sum[cec_pkg::TOTAL_W-1:0];
            end
            if (grid_done) begin
                result_next  = total_next;
                m_valid_next = 1'b1;
                row_next     = '0;
                col_next     = '0;
                total_next   = '0;
            end else if (last_col) begin
                col_next = '0;
                row_next = row_reg + cec_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + cec_pkg::COL_W'(1);
            end
        end

        // a write to either grid-size register restarts the grid; line cells keep their bits
        if (cfg_accept) begin
            case (cfg_index)
                cec_pkg::REG_GRID_ROWS: begin
                    rows_m1_next = cec_pkg::rows_m1_of(cfg_data);
                    row_next     = '0;
                    col_next     = '0;
                    total_next   = '0;
                end
                cec_pkg::REG_GRID_COLS: begin
                    cols_m1_next = cec_pkg::cols_m1_of(cfg_data);
                    row_next     = '0;
                    col_next     = '0;
                    total_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m1_reg <= '0;
            cols_m1_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rows_m1_reg <= rows_m1_next;
            cols_m1_reg <= cols_m1_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg     <= result_next;
        hist_above_reg <= hist_above_next;
        hist_cur1_reg  <= hist_cur1_next;
        hist_cur2_reg  <= hist_cur2_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_empty_core_total = result_reg;

endmodule

FILE: design/cec_cell.sv
// One column slot of the line-buffer chain: loads at the head, else shifts from its neighbor.
module cec_cell (
    input  logic                aclk,
    input  logic                shift_en,
    input  logic                is_head,
    input  cec_pkg::line_bits_t load_bits,
    input  cec_pkg::line_bits_t next_bits,
    output cec_pkg::line_bits_t bits
);

    cec_pkg::line_bits_t bits_reg;
    cec_pkg::line_bits_t bits_next;

    always_comb begin
        bits_next = bits_reg;
        if (shift_en) begin
            bits_next = is_head ? load_bits : next_bits;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
    end

    assign bits = bits_reg;

endmodule

FILE: design/cec_checker.sv
// Port-level checks for the cross erosion cell counter, bound to the top level.
module cec_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [cec_pkg::TOTAL_W-1:0]   m_empty_core_total
);

    // reset leaves no total pending
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a total appears only right after a cell transaction
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("total appeared without a cell transaction");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    a_hold_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_empty_core_total))
        else $error("total changed while stalled");

endmodule

bind cross_erosion_cell_counter cec_checker u_cec_checker (.*);
